// File: src/fri_pkg.sv
`default_nettype none
package fri_pkg;

    localparam int MAX_FACTORS_DEF  = 1024;
    localparam int MAX_BUCKETS_DEF  = 256;
    localparam int BUCKET_DEPTH_DEF = 32;
    localparam int MAX_MATCHES_DEF  = 64;

    localparam logic [31:0] SPAN_RESET = 32'd1024;

    localparam logic [1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [1:0] CFG_SPAN    = 2'd1;
    localparam logic [1:0] CFG_REF_LEN = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FAC_FULL = 2'd1;
    localparam logic [1:0] ST_BKT_FULL = 2'd2;
    localparam logic [1:0] ST_CAP      = 2'd3;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] ref_pos;
        logic [31:0] length;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [32:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DFIN, S_DB0, S_DB1,
        S_AFILL, S_AWR, S_AEND,
        S_QFILL, S_QFGOT, S_QMEM, S_QMGOT, S_QCHK, S_QEND
    } back_state_t;

endpackage
`default_nettype wire

// File: src/factor_range_index_core.sv
// channel   | dir | tdata                         | tuser              | tlast
// s_*       | in  | [31:0] ref_pos, [63:32] length| [0] action         | -
// m_*       | out | [31:0] position                | [0] found, [2:1] st| last
// cfg_*     | in  | cfg_index picks register, cfg_data its value, cfg_we writes
// Each word passes a two-entry queue to a sequencer that runs three 33-step
// serial divisions (final bucket, first and last bucket), then on an add reads
// and updates the fill of each bucket, or on a query reads each bucket's fill
// and checks each listed factor, and ends with the result word.
// After reset the bucket fill table is cleared; no input word is started
// during that pass. A stalled result register holds the sequencer; the queue
// keeps taking words until it is full.
`default_nettype none
module factor_range_index_core #(
    parameter int MAX_FACTORS  = fri_pkg::MAX_FACTORS_DEF,
    parameter int MAX_BUCKETS  = fri_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = fri_pkg::BUCKET_DEPTH_DEF,
    parameter int MAX_MATCHES  = fri_pkg::MAX_MATCHES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // ref_pos, length
    input  wire         s_tuser,   // action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // position
    output logic [2:0]  m_tuser,   // found, status
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    logic [31:0]    min_len_reg, span_reg, ref_len_reg;
    fri_pkg::item_t in_item, head;
    logic           q_full, q_empty, q_pop, push;
    logic           found;
    logic [1:0]     status;

    assign in_item.action  = s_tuser;
    assign in_item.ref_pos = s_tdata[31:0];
    assign in_item.length  = s_tdata[63:32];
    assign s_tready        = !q_full;
    assign push            = s_tvalid && !q_full;
    assign m_tuser         = {status, found};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= 32'd0;
            span_reg    <= fri_pkg::SPAN_RESET;
            ref_len_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fri_pkg::CFG_MIN_LEN: min_len_reg <= cfg_data;
                fri_pkg::CFG_SPAN:    span_reg    <= cfg_data;
                fri_pkg::CFG_REF_LEN: ref_len_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    fri_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty)
    );

    fri_back #(
        .MAX_FACTORS  (MAX_FACTORS),
        .MAX_BUCKETS  (MAX_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH),
        .MAX_MATCHES  (MAX_MATCHES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_len      (min_len_reg),
        .span         (span_reg),
        .ref_len      (ref_len_reg),
        .head         (head),
        .empty        (q_empty),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_position (m_tdata),
        .out_found    (found),
        .out_last     (m_tlast),
        .out_status   (status)
    );
endmodule
`default_nettype wire

// File: src/fri_queue.sv
`default_nettype none
module fri_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  fri_pkg::item_t      push_item,
    output logic                full,
    input  wire                 pop,
    output fri_pkg::item_t      head,
    output logic                empty
);
    fri_pkg::item_t slot_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

// File: src/fri_div.sv
`default_nettype none
module fri_div (
    input  wire                 clk,
    input  wire                 rst_n,
    input  fri_pkg::div_req_t   req,
    output fri_pkg::div_rsp_t   rsp
);
    logic        busy_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg, dv_reg;
    logic [32:0] quo_reg;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[32]};
    assign ge    = (trial >= {1'b0, dv_reg});
    assign diff  = trial - {1'b0, dv_reg};

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= 32'd0;
            quo_reg <= req.dividend;
            dv_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[31:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: src/fri_back.sv
`default_nettype none
module fri_back #(
    parameter int MAX_FACTORS  = fri_pkg::MAX_FACTORS_DEF,
    parameter int MAX_BUCKETS  = fri_pkg::MAX_BUCKETS_DEF,
    parameter int BUCKET_DEPTH = fri_pkg::BUCKET_DEPTH_DEF,
    parameter int MAX_MATCHES  = fri_pkg::MAX_MATCHES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  [31:0]         min_len,
    input  wire  [31:0]         span,
    input  wire  [31:0]         ref_len,
    input  fri_pkg::item_t      head,
    input  wire                 empty,
    output logic                pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [31:0]         out_position,
    output logic                out_found,
    output logic                out_last,
    output logic [1:0]          out_status
);
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int MD = MAX_BUCKETS * BUCKET_DEPTH;
    localparam int MW = (MD > 1) ? $clog2(MD) : 1;
    localparam int NW = $clog2(MAX_MATCHES + 1);
    localparam int LW = $clog2(MAX_BUCKETS + 1);

    // storage
    logic [31:0]   fstart_mem [MAX_FACTORS];
    logic [31:0]   flen_mem   [MAX_FACTORS];
    logic [31:0]   fseq_mem   [MAX_FACTORS];
    logic [FW-1:0] fill_mem   [MAX_BUCKETS];
    logic [IW-1:0] memb_mem   [MD];

    logic [31:0]   fstart_rd, flen_rd, fseq_rd;
    logic [FW-1:0] fill_rd;
    logic [IW-1:0] memb_rd;

    logic          fac_we;
    logic [IW-1:0] fac_waddr, fac_raddr;
    logic          fill_we;
    logic [BW-1:0] fill_waddr, fill_raddr;
    logic [FW-1:0] fill_wdata;
    logic          memb_we;
    logic [MW-1:0] memb_waddr, memb_raddr;

    fri_pkg::back_state_t state_reg, state_next;
    fri_pkg::div_req_t    dreq;
    fri_pkg::div_rsp_t    drsp;

    logic          act_reg;
    logic [31:0]   pos_reg, len_reg, seq_reg, seqctr_reg;
    logic [BW-1:0] fin_reg, b_reg, b1_reg;
    logic [32:0]   b0q_reg;
    logic [IW-1:0] idx_reg;
    logic [FW-1:0] i_reg, f_reg;
    logic [NW-1:0] n_reg;
    logic [1:0]    status_reg;
    logic [CW-1:0] count_reg;
    logic          pend_valid_reg, capped_reg;
    logic [31:0]   pend_pos_reg;
    logic [LW-1:0] clr_reg;
    logic          clearing;

    logic          out_free, emit;
    logic [31:0]   emit_pos;
    logic          emit_found, emit_last;
    logic [1:0]    emit_status;

    logic [32:0]   qend, fend, mpos, adv;
    logic [BW-1:0] fin_c, b0c, b1c;
    logic          hit;

    fri_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    function automatic logic [BW-1:0] clamp(input logic [32:0] q, input logic [BW-1:0] lim);
        clamp = (q > {{(33-BW){1'b0}}, lim}) ? lim : q[BW-1:0];
    endfunction

    assign clearing  = (clr_reg != LW'(MAX_BUCKETS));
    assign out_free  = !out_valid || out_ready;
    assign qend      = {1'b0, pos_reg} + {1'b0, len_reg};
    assign fend      = {1'b0, fstart_rd} + {1'b0, flen_rd};
    assign hit       = (pos_reg >= fstart_rd) && (qend <= fend);
    assign mpos      = {1'b0, fseq_rd} + {1'b0, pos_reg - fstart_rd};
    assign adv       = {1'b0, seqctr_reg} + {1'b0, len_reg};
    assign fin_c     = clamp(drsp.quotient, BW'(MAX_BUCKETS - 1));
    assign b0c       = clamp(b0q_reg, fin_reg);
    assign b1c       = clamp(drsp.quotient, fin_reg);
    assign fac_waddr = count_reg[IW-1:0];
    assign fac_raddr = memb_rd;
    assign fill_raddr = b_reg;
    assign memb_raddr = MW'(b_reg) * MW'(BUCKET_DEPTH) + MW'(i_reg);
    assign memb_waddr = MW'(b_reg) * MW'(BUCKET_DEPTH) + MW'(fill_rd);

    always_ff @(posedge clk)
    begin
        if (fac_we)
        begin
            fstart_mem[fac_waddr] <= pos_reg;
            flen_mem[fac_waddr]   <= len_reg;
            fseq_mem[fac_waddr]   <= seqctr_reg;
        end
        fstart_rd <= fstart_mem[fac_raddr];
        flen_rd   <= flen_mem[fac_raddr];
        fseq_rd   <= fseq_mem[fac_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_waddr] <= fill_wdata;
        fill_rd <= fill_mem[fill_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (memb_we)
            memb_mem[memb_waddr] <= idx_reg;
        memb_rd <= memb_mem[memb_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        pop           = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = {1'b0, ref_len};
        dreq.divisor  = (span == 32'd0) ? 32'd1 : span;
        fac_we        = 1'b0;
        fill_we       = 1'b0;
        fill_waddr    = b_reg;
        fill_wdata    = fill_rd + FW'(1);
        memb_we       = 1'b0;
        emit          = 1'b0;
        emit_pos      = pend_pos_reg;
        emit_found    = 1'b1;
        emit_last     = 1'b0;
        emit_status   = fri_pkg::ST_OK;
        if (clearing)
        begin
            fill_we    = 1'b1;
            fill_waddr = clr_reg[BW-1:0];
            fill_wdata = '0;
        end
        case (state_reg)
            fri_pkg::S_IDLE:
            begin
                if (!empty && !clearing)
                begin
                    pop        = 1'b1;
                    dreq.start = 1'b1;
                    state_next = fri_pkg::S_DFIN;
                end
            end
            fri_pkg::S_DFIN:
            begin
                if (drsp.done)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = {1'b0, pos_reg};
                    state_next    = fri_pkg::S_DB0;
                end
            end
            fri_pkg::S_DB0:
            begin
                if (drsp.done)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = qend;
                    state_next    = fri_pkg::S_DB1;
                end
            end
            fri_pkg::S_DB1:
            begin
                if (drsp.done)
                begin
                    if (act_reg == fri_pkg::ACT_ADD)
                    begin
                        if (len_reg >= min_len && count_reg != CW'(MAX_FACTORS))
                        begin
                            fac_we     = 1'b1;
                            state_next = fri_pkg::S_AFILL;
                        end
                        else
                            state_next = fri_pkg::S_AEND;
                    end
                    else if (b0q_reg > {{(33-BW){1'b0}}, b1c})
                        state_next = fri_pkg::S_QEND;
                    else
                        state_next = fri_pkg::S_QFILL;
                end
            end
            fri_pkg::S_AFILL:
                state_next = fri_pkg::S_AWR;
            fri_pkg::S_AWR:
            begin
                if (fill_rd != FW'(BUCKET_DEPTH))
                begin
                    fill_we = 1'b1;
                    memb_we = 1'b1;
                end
                state_next = (b_reg == b1_reg) ? fri_pkg::S_AEND : fri_pkg::S_AFILL;
            end
            fri_pkg::S_AEND:
            begin
                if (out_free)
                begin
                    emit        = 1'b1;
                    emit_pos    = seq_reg;
                    emit_found  = 1'b0;
                    emit_last   = 1'b1;
                    emit_status = status_reg;
                    state_next  = fri_pkg::S_IDLE;
                end
            end
            fri_pkg::S_QFILL:
                state_next = fri_pkg::S_QFGOT;
            fri_pkg::S_QFGOT:
            begin
                if (fill_rd != '0)
                    state_next = fri_pkg::S_QMEM;
                else if (b_reg == b1_reg)
                    state_next = fri_pkg::S_QEND;
                else
                    state_next = fri_pkg::S_QFILL;
            end
            fri_pkg::S_QMEM:
                state_next = fri_pkg::S_QMGOT;
            fri_pkg::S_QMGOT:
                state_next = fri_pkg::S_QCHK;
            fri_pkg::S_QCHK:
            begin
                if (hit && n_reg == NW'(MAX_MATCHES))
                    state_next = fri_pkg::S_QEND;
                else if (!hit || !pend_valid_reg || out_free)
                begin
                    emit = hit && pend_valid_reg;
                    if (i_reg + FW'(1) != f_reg)
                        state_next = fri_pkg::S_QMEM;
                    else if (b_reg == b1_reg)
                        state_next = fri_pkg::S_QEND;
                    else
                        state_next = fri_pkg::S_QFILL;
                end
            end
            fri_pkg::S_QEND:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    if (!pend_valid_reg)
                    begin
                        emit_pos   = 32'd0;
                        emit_found = 1'b0;
                    end
                    else if (capped_reg)
                        emit_status = fri_pkg::ST_CAP;
                    state_next = fri_pkg::S_IDLE;
                end
            end
            default:
                state_next = fri_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            act_reg <= head.action;
            pos_reg <= head.ref_pos;
            len_reg <= head.length;
        end
        if (state_reg == fri_pkg::S_DFIN && drsp.done)
            fin_reg <= fin_c;
        if (state_reg == fri_pkg::S_DB0 && drsp.done)
            b0q_reg <= drsp.quotient;
        if (state_reg == fri_pkg::S_DB1 && drsp.done)
        begin
            b1_reg  <= b1c;
            b_reg   <= (act_reg == fri_pkg::ACT_ADD) ? b0c : b0q_reg[BW-1:0];
            idx_reg <= count_reg[IW-1:0];
            seq_reg <= seqctr_reg;
        end
        if (state_reg == fri_pkg::S_AWR || state_reg == fri_pkg::S_QFGOT
            || state_reg == fri_pkg::S_QCHK)
        begin
            if (state_next == fri_pkg::S_AFILL || state_next == fri_pkg::S_QFILL)
                b_reg <= b_reg + BW'(1);
        end
        if (state_reg == fri_pkg::S_QFGOT)
        begin
            f_reg <= fill_rd;
            i_reg <= '0;
        end
        if (state_reg == fri_pkg::S_QCHK && state_next == fri_pkg::S_QMEM)
            i_reg <= i_reg + FW'(1);
        if (state_reg == fri_pkg::S_QCHK && hit && state_next != fri_pkg::S_QCHK
            && n_reg != NW'(MAX_MATCHES))
            pend_pos_reg <= mpos[32] ? 32'hFFFF_FFFF : mpos[31:0];
        if (emit)
        begin
            out_position <= emit_pos;
            out_found    <= emit_found;
            out_last     <= emit_last;
            out_status   <= emit_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fri_pkg::S_IDLE;
            clr_reg        <= '0;
            count_reg      <= '0;
            seqctr_reg     <= 32'd0;
            status_reg     <= fri_pkg::ST_OK;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            capped_reg     <= 1'b0;
            out_valid      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + LW'(1);
            if (pop)
            begin
                status_reg     <= fri_pkg::ST_OK;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
                capped_reg     <= 1'b0;
            end
            if (state_reg == fri_pkg::S_DB1 && drsp.done && act_reg == fri_pkg::ACT_ADD)
            begin
                seqctr_reg <= adv[32] ? 32'hFFFF_FFFF : adv[31:0];
                if (len_reg >= min_len)
                begin
                    if (count_reg == CW'(MAX_FACTORS))
                        status_reg <= fri_pkg::ST_FAC_FULL;
                    else
                        count_reg <= count_reg + CW'(1);
                end
            end
            if (state_reg == fri_pkg::S_AWR && fill_rd == FW'(BUCKET_DEPTH))
                status_reg <= fri_pkg::ST_BKT_FULL;
            if (state_reg == fri_pkg::S_QCHK && hit)
            begin
                if (n_reg == NW'(MAX_MATCHES))
                    capped_reg <= 1'b1;
                else if (state_next != fri_pkg::S_QCHK)
                begin
                    n_reg          <= n_reg + NW'(1);
                    pend_valid_reg <= 1'b1;
                end
            end
            if (state_reg == fri_pkg::S_QEND && out_free)
                pend_valid_reg <= 1'b0;
            if (emit)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end
endmodule
`default_nettype wire
